/* design/sgi_pkg.sv */
// Shared constants, widths and control types for the segment intersection block.
`timescale 1ns / 1ps
package sgi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int TOL_WIDTH = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd66;

  localparam int FUNC_WIDTH = 2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_LINE_LINE = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_LINE_SEG  = 2'd1;

  function automatic int quot_width(int cw);
    return ((cw > TOL_WIDTH + 1) ? cw : TOL_WIDTH + 1) + 2;
  endfunction

  typedef struct packed {
    logic parallel;
    logic neg_x;
    logic neg_y;
  } sgi_ctl_t;

endpackage

/* design/sgi_coef.sv */
// Coefficient, determinant and Cramer numerator pipeline (six stages).
`timescale 1ns / 1ps
module sgi_coef #(
  parameter int W = sgi_pkg::COORD_WIDTH_DEF,
  localparam int VW = sgi_pkg::quot_width(W) + 2,
  localparam int NW = 3 * W + 3,
  localparam int DW = 2 * W + 3,
  localparam int SW = sgi_pkg::FUNC_WIDTH + 8 * VW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sgi_pkg::TOL_WIDTH-1:0]     tol,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sgi_pkg::FUNC_WIDTH-1:0]    in_func,
  input  logic [8*W-1:0]                    in_coord,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [NW-1:0]                     out_nx,
  output logic [NW-1:0]                     out_ny,
  output logic [DW-1:0]                     out_den,
  output sgi_pkg::sgi_ctl_t                 out_ctl,
  output logic [SW-1:0]                     out_side
);
  import sgi_pkg::*;

  localparam int NS = 6;
  localparam int PW = 3 * W + 2;

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic [NS-1:0] ld;

  assign rdy = ~vld | {out_ready, rdy[NS-1:1]};
  assign ld  = rdy & {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1];
        end
      end
    end
  end

  function automatic logic signed [VW-1:0] box_lo(logic signed [W-1:0] p,
                                                  logic signed [W-1:0] q,
                                                  logic [TOL_WIDTH-1:0] t);
    logic signed [W-1:0] m;
    m = (p < q) ? p : q;
    return VW'(m) - $signed(VW'({1'b0, t}));
  endfunction

  function automatic logic signed [VW-1:0] box_hi(logic signed [W-1:0] p,
                                                  logic signed [W-1:0] q,
                                                  logic [TOL_WIDTH-1:0] t);
    logic signed [W-1:0] m;
    m = (p < q) ? q : p;
    return VW'(m) + $signed(VW'({1'b0, t}));
  endfunction

  logic signed [W-1:0] crd [8];
  logic [SW-1:0] side_in;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      crd[i] = $signed(in_coord[i*W +: W]);
    end
    side_in = {box_hi(crd[1], crd[3], tol), box_lo(crd[1], crd[3], tol),
               box_hi(crd[0], crd[2], tol), box_lo(crd[0], crd[2], tol),
               box_hi(crd[5], crd[7], tol), box_lo(crd[5], crd[7], tol),
               box_hi(crd[4], crd[6], tol), box_lo(crd[4], crd[6], tol),
               in_func};
  end

  logic signed [W:0]     s1_a1, s1_b1, s1_a2, s1_b2;
  logic signed [2*W-1:0] s1_pab, s1_pba, s1_pcd, s1_pdc;
  logic [SW-1:0]         s1_side;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_a1  <= (W+1)'(crd[1]) - (W+1)'(crd[3]);
      s1_b1  <= (W+1)'(crd[2]) - (W+1)'(crd[0]);
      s1_a2  <= (W+1)'(crd[5]) - (W+1)'(crd[7]);
      s1_b2  <= (W+1)'(crd[6]) - (W+1)'(crd[4]);
      s1_pab <= crd[0] * crd[3];
      s1_pba <= crd[2] * crd[1];
      s1_pcd <= crd[4] * crd[7];
      s1_pdc <= crd[6] * crd[5];
      s1_side <= side_in;
    end
  end

  logic signed [2*W:0]   s2_c1, s2_c2;
  logic signed [2*W+1:0] s2_m1, s2_m2;
  logic signed [W:0]     s2_a1, s2_b1, s2_a2, s2_b2;
  logic [SW-1:0]         s2_side;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_c1 <= (2*W+1)'(s1_pab) - (2*W+1)'(s1_pba);
      s2_c2 <= (2*W+1)'(s1_pcd) - (2*W+1)'(s1_pdc);
      s2_m1 <= s1_a1 * s1_b2;
      s2_m2 <= s1_a2 * s1_b1;
      s2_a1 <= s1_a1;
      s2_b1 <= s1_b1;
      s2_a2 <= s1_a2;
      s2_b2 <= s1_b2;
      s2_side <= s1_side;
    end
  end

  logic signed [W-1:0] c1h, c2h;
  logic signed [W+1:0] c1l, c2l;

  assign c1h = $signed(s2_c1[2*W:W+1]);
  assign c2h = $signed(s2_c2[2*W:W+1]);
  assign c1l = $signed({1'b0, s2_c1[W:0]});
  assign c2l = $signed({1'b0, s2_c2[W:0]});

  logic signed [DW-1:0]  s3_den;
  logic signed [2*W:0]   s3_c1b2h, s3_c2b1h, s3_a1c2h, s3_a2c1h;
  logic signed [2*W+2:0] s3_c1b2l, s3_c2b1l, s3_a1c2l, s3_a2c1l;
  logic [SW-1:0]         s3_side;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_den   <= DW'(s2_m1) - DW'(s2_m2);
      s3_c1b2h <= c1h * s2_b2;
      s3_c1b2l <= c1l * s2_b2;
      s3_c2b1h <= c2h * s2_b1;
      s3_c2b1l <= c2l * s2_b1;
      s3_a1c2h <= c2h * s2_a1;
      s3_a1c2l <= c2l * s2_a1;
      s3_a2c1h <= c1h * s2_a2;
      s3_a2c1l <= c1l * s2_a2;
      s3_side  <= s2_side;
    end
  end

  logic signed [DW-1:0] s4_den;
  logic signed [PW-1:0] s4_c1b2, s4_c2b1, s4_a1c2, s4_a2c1;
  logic [SW-1:0]        s4_side;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_den  <= s3_den;
      s4_c1b2 <= (PW'(s3_c1b2h) <<< (W + 1)) + PW'(s3_c1b2l);
      s4_c2b1 <= (PW'(s3_c2b1h) <<< (W + 1)) + PW'(s3_c2b1l);
      s4_a1c2 <= (PW'(s3_a1c2h) <<< (W + 1)) + PW'(s3_a1c2l);
      s4_a2c1 <= (PW'(s3_a2c1h) <<< (W + 1)) + PW'(s3_a2c1l);
      s4_side <= s3_side;
    end
  end

  logic signed [NW-1:0] s5_nx, s5_ny;
  logic [DW-1:0]        s5_den;
  logic                 s5_den_zero, s5_den_neg;
  logic [SW-1:0]        s5_side;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_nx       <= NW'(s4_c1b2) - NW'(s4_c2b1);
      s5_ny       <= NW'(s4_a1c2) - NW'(s4_a2c1);
      s5_den      <= s4_den[DW-1] ? DW'(-s4_den) : DW'(s4_den);
      s5_den_zero <= (s4_den == '0);
      s5_den_neg  <= s4_den[DW-1];
      s5_side     <= s4_side;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      out_nx           <= s5_nx[NW-1] ? NW'(-s5_nx) : NW'(s5_nx);
      out_ny           <= s5_ny[NW-1] ? NW'(-s5_ny) : NW'(s5_ny);
      out_den          <= s5_den;
      out_ctl.parallel <= s5_den_zero;
      out_ctl.neg_x    <= (s5_nx[NW-1] == s5_den_neg);
      out_ctl.neg_y    <= (s5_ny[NW-1] == s5_den_neg);
      out_side         <= s5_side;
    end
  end

endmodule

/* design/sgi_div.sv */
// Restoring divider, one quotient bit per stage, two numerator lanes over one divisor.
`timescale 1ns / 1ps
module sgi_div #(
  parameter int W = sgi_pkg::COORD_WIDTH_DEF,
  localparam int QW = sgi_pkg::quot_width(W),
  localparam int VW = QW + 2,
  localparam int NW = 3 * W + 3,
  localparam int DW = 2 * W + 3,
  localparam int SW = sgi_pkg::FUNC_WIDTH + 8 * VW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NW-1:0]     in_nx,
  input  logic [NW-1:0]     in_ny,
  input  logic [DW-1:0]     in_den,
  input  sgi_pkg::sgi_ctl_t in_ctl,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [QW-1:0]     out_qx,
  output logic [QW-1:0]     out_qy,
  output logic [DW-1:0]     out_rx,
  output logic [DW-1:0]     out_ry,
  output logic [DW-1:0]     out_den,
  output logic              out_ovx,
  output logic              out_ovy,
  output sgi_pkg::sgi_ctl_t out_ctl,
  output logic [SW-1:0]     out_side
);
  import sgi_pkg::*;

  localparam int NS = QW + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic [NS-1:0] ld;

  assign rdy = ~vld | {out_ready, rdy[NS-1:1]};
  assign ld  = rdy & {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1];
        end
      end
    end
  end

  logic [DW-1:0] rem_x [NS];
  logic [DW-1:0] rem_y [NS];
  logic [QW-1:0] bits_x [NS];
  logic [QW-1:0] bits_y [NS];
  logic [DW-1:0] den [NS];
  logic          ovx [NS];
  logic          ovy [NS];
  sgi_ctl_t      ctl [NS];
  logic [SW-1:0] side [NS];

  logic [DW-1:0] top_x, top_y;
  logic          gx, gy;

  assign top_x = DW'(in_nx >> QW);
  assign top_y = DW'(in_ny >> QW);
  assign gx = (top_x >= in_den);
  assign gy = (top_y >= in_den);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_x[0]  <= gx ? '0 : top_x;
      rem_y[0]  <= gy ? '0 : top_y;
      bits_x[0] <= in_nx[QW-1:0];
      bits_y[0] <= in_ny[QW-1:0];
      ovx[0]    <= gx;
      ovy[0]    <= gy;
      den[0]    <= in_den;
      ctl[0]    <= in_ctl;
      side[0]   <= in_side;
    end
  end

  for (genvar g = 1; g < NS; g++) begin : g_step
    logic [DW:0] tx, ty;
    logic        sx, sy;

    assign tx = {rem_x[g-1], bits_x[g-1][QW-1]};
    assign ty = {rem_y[g-1], bits_y[g-1][QW-1]};
    assign sx = (tx >= {1'b0, den[g-1]});
    assign sy = (ty >= {1'b0, den[g-1]});

    always_ff @(posedge clk) begin
      if (ld[g]) begin
        rem_x[g]  <= sx ? DW'(tx - {1'b0, den[g-1]}) : DW'(tx);
        rem_y[g]  <= sy ? DW'(ty - {1'b0, den[g-1]}) : DW'(ty);
        bits_x[g] <= {bits_x[g-1][QW-2:0], sx};
        bits_y[g] <= {bits_y[g-1][QW-2:0], sy};
        ovx[g]    <= ovx[g-1];
        ovy[g]    <= ovy[g-1];
        den[g]    <= den[g-1];
        ctl[g]    <= ctl[g-1];
        side[g]   <= side[g-1];
      end
    end
  end

  assign out_qx   = bits_x[NS-1];
  assign out_qy   = bits_y[NS-1];
  assign out_rx   = rem_x[NS-1];
  assign out_ry   = rem_y[NS-1];
  assign out_den  = den[NS-1];
  assign out_ovx  = ovx[NS-1];
  assign out_ovy  = ovy[NS-1];
  assign out_ctl  = ctl[NS-1];
  assign out_side = side[NS-1];

endmodule

/* design/sgi_fin.sv */
// Rounding, sign, bounding box tests, saturation and output register.
`timescale 1ns / 1ps
module sgi_fin #(
  parameter int W = sgi_pkg::COORD_WIDTH_DEF,
  localparam int QW = sgi_pkg::quot_width(W),
  localparam int VW = QW + 2,
  localparam int DW = 2 * W + 3,
  localparam int SW = sgi_pkg::FUNC_WIDTH + 8 * VW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [QW-1:0]     in_qx,
  input  logic [QW-1:0]     in_qy,
  input  logic [DW-1:0]     in_rx,
  input  logic [DW-1:0]     in_ry,
  input  logic [DW-1:0]     in_den,
  input  logic              in_ovx,
  input  logic              in_ovy,
  input  sgi_pkg::sgi_ctl_t in_ctl,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic              out_parallel,
  output logic [W-1:0]      out_cross_x,
  output logic [W-1:0]      out_cross_y,
  output logic              out_saturated
);
  import sgi_pkg::*;

  localparam int NS = 3;
  localparam logic signed [VW-1:0] SAT_HI = $signed({{(VW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [QW:0] CLAMP = {1'b1, {QW{1'b0}}};

  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic [NS-1:0] ld;

  assign rdy = ~vld | {out_ready, rdy[NS-1:1]};
  assign ld  = rdy & {vld[NS-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1];
        end
      end
    end
  end

  logic [QW-1:0] f1_qx, f1_qy;
  logic          f1_rbx, f1_rby, f1_ovx, f1_ovy;
  sgi_ctl_t      f1_ctl;
  logic [SW-1:0] f1_side;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      f1_qx   <= in_qx;
      f1_qy   <= in_qy;
      f1_rbx  <= ({in_rx, 1'b0} >= {1'b0, in_den});
      f1_rby  <= ({in_ry, 1'b0} >= {1'b0, in_den});
      f1_ovx  <= in_ovx;
      f1_ovy  <= in_ovy;
      f1_ctl  <= in_ctl;
      f1_side <= in_side;
    end
  end

  logic [QW:0]          mag_x, mag_y;
  logic signed [VW-1:0] f2_vx, f2_vy;
  logic                 f2_par;
  logic [SW-1:0]        f2_side;

  assign mag_x = f1_ovx ? CLAMP : ({1'b0, f1_qx} + (QW+1)'(f1_rbx));
  assign mag_y = f1_ovy ? CLAMP : ({1'b0, f1_qy} + (QW+1)'(f1_rby));

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      f2_vx   <= f1_ctl.neg_x ? -$signed(VW'(mag_x)) : $signed(VW'(mag_x));
      f2_vy   <= f1_ctl.neg_y ? -$signed(VW'(mag_y)) : $signed(VW'(mag_y));
      f2_par  <= f1_ctl.parallel;
      f2_side <= f1_side;
    end
  end

  logic signed [VW-1:0]   bnd [8];
  logic [FUNC_WIDTH-1:0]  func;
  logic                   in_first, in_second, hit_n, sx_hi, sx_lo, sy_hi, sy_lo;
  logic [FUNC_WIDTH-1:0]  f3_func;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bnd[i] = $signed(f2_side[FUNC_WIDTH + i*VW +: VW]);
    end
    func      = f2_side[FUNC_WIDTH-1:0];
    in_second = (f2_vx >= bnd[0]) && (f2_vx <= bnd[1]) &&
                (f2_vy >= bnd[2]) && (f2_vy <= bnd[3]);
    in_first  = (f2_vx >= bnd[4]) && (f2_vx <= bnd[5]) &&
                (f2_vy >= bnd[6]) && (f2_vy <= bnd[7]);
    if (func == FUNC_LINE_LINE) begin
      hit_n = 1'b1;
    end else if (func == FUNC_LINE_SEG) begin
      hit_n = in_second;
    end else begin
      hit_n = in_second && in_first;
    end
    sx_hi = (f2_vx > SAT_HI);
    sx_lo = (f2_vx < SAT_LO);
    sy_hi = (f2_vy > SAT_HI);
    sy_lo = (f2_vy < SAT_LO);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      f3_func <= func;
      if (f2_par) begin
        out_hit       <= 1'b0;
        out_parallel  <= 1'b1;
        out_cross_x   <= '0;
        out_cross_y   <= '0;
        out_saturated <= 1'b0;
      end else begin
        out_hit       <= hit_n;
        out_parallel  <= 1'b0;
        out_cross_x   <= sx_hi ? SAT_HI[W-1:0] : sx_lo ? SAT_LO[W-1:0] : f2_vx[W-1:0];
        out_cross_y   <= sy_hi ? SAT_HI[W-1:0] : sy_lo ? SAT_LO[W-1:0] : f2_vy[W-1:0];
        out_saturated <= sx_hi || sx_lo || sy_hi || sy_lo;
      end
    end
  end

  a_parallel_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_parallel |-> !out_hit && out_cross_x == '0 && out_cross_y == '0
                                  && !out_saturated)
    else $error("parallel result carries a point or a hit");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_saturated |->
      out_cross_x == SAT_HI[W-1:0] || out_cross_x == SAT_LO[W-1:0] ||
      out_cross_y == SAT_HI[W-1:0] || out_cross_y == SAT_LO[W-1:0])
    else $error("saturated flag without an extreme coordinate");

  a_line_line_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_parallel && f3_func == FUNC_LINE_LINE |-> out_hit)
    else $error("line-line crossing reported as a miss");

endmodule

/* design/segment_intersection_2d.sv */
// Throughput: one segment pair per cycle unless m_tready holds the output back; six
// arithmetic stages, then the restoring divider retires one quotient bit per stage
// for both coordinates, then three stages of rounding, box tests and saturation.
// Reset clears every valid bit and sets tolerance to 66.
`timescale 1ns / 1ps
module segment_intersection_2d #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF,
  localparam int MTW = ((2 * COORD_WIDTH + 3 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgi_pkg::TOL_WIDTH-1:0]  cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [8*COORD_WIDTH-1:0]       s_tdata,
  // func
  input  logic [sgi_pkg::FUNC_WIDTH-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit, parallel, cross_x, cross_y, saturated, zero fill
  output logic [MTW-1:0]                 m_tdata
);
  import sgi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int QW = quot_width(W);
  localparam int VW = QW + 2;
  localparam int NW = 3 * W + 3;
  localparam int DW = 2 * W + 3;
  localparam int SW = FUNC_WIDTH + 8 * VW;

  logic [TOL_WIDTH-1:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  logic          c_valid, c_ready;
  logic [NW-1:0] c_nx, c_ny;
  logic [DW-1:0] c_den;
  sgi_ctl_t      c_ctl;
  logic [SW-1:0] c_side;

  sgi_coef #(.W(W)) u_coef (
    .clk       (clk),
    .rst       (rst),
    .tol       (tolerance),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_coord  (s_tdata),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_nx    (c_nx),
    .out_ny    (c_ny),
    .out_den   (c_den),
    .out_ctl   (c_ctl),
    .out_side  (c_side)
  );

  logic          d_valid, d_ready;
  logic [QW-1:0] d_qx, d_qy;
  logic [DW-1:0] d_rx, d_ry, d_den;
  logic          d_ovx, d_ovy;
  sgi_ctl_t      d_ctl;
  logic [SW-1:0] d_side;

  sgi_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_nx     (c_nx),
    .in_ny     (c_ny),
    .in_den    (c_den),
    .in_ctl    (c_ctl),
    .in_side   (c_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_qx    (d_qx),
    .out_qy    (d_qy),
    .out_rx    (d_rx),
    .out_ry    (d_ry),
    .out_den   (d_den),
    .out_ovx   (d_ovx),
    .out_ovy   (d_ovy),
    .out_ctl   (d_ctl),
    .out_side  (d_side)
  );

  logic         hit, parallel, saturated;
  logic [W-1:0] cross_x, cross_y;

  sgi_fin #(.W(W)) u_fin (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (d_valid),
    .in_ready      (d_ready),
    .in_qx         (d_qx),
    .in_qy         (d_qy),
    .in_rx         (d_rx),
    .in_ry         (d_ry),
    .in_den        (d_den),
    .in_ovx        (d_ovx),
    .in_ovy        (d_ovy),
    .in_ctl        (d_ctl),
    .in_side       (d_side),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_hit       (hit),
    .out_parallel  (parallel),
    .out_cross_x   (cross_x),
    .out_cross_y   (cross_y),
    .out_saturated (saturated)
  );

  assign m_tdata = {(MTW-2*W-3)'(0), saturated, cross_y, cross_x, parallel, hit};

endmodule

/* tb/segment_intersection_2d_tb.sv */
// Self-checking testbench for the 2D segment intersection block.
`timescale 1ns / 1ps
module segment_intersection_2d_tb;
  import sgi_pkg::*;

  localparam int CW = 32;
  localparam int RW = 72;
  localparam int LATENCY = quot_width(CW) + 10;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SEG_SEG = 2'd2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [FUNC_WIDTH-1:0] func;
    logic signed [CW-1:0] pt[8];
  } seg_pair_t;

  class crossing_scoreboard;
    logic [RW-1:0] pending[$];
    logic [TOL_WIDTH-1:0] tolerance;
    int errors;
    int checked;
    int hits;
    int parallels;
    int saturations;

    function new();
      tolerance = TOL_RESET;
    endfunction

    function logic signed [65:0] rounded_quot(logic signed [191:0] n, logic signed [191:0] d);
      logic [191:0] mn;
      logic [191:0] md;
      logic [191:0] q;
      logic [191:0] r;
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = mn / md;
      r = mn % md;
      if ((r << 1) >= md) q = q + 1;
      if (q > (192'd1 << 62)) q = 192'd1 << 62;
      return ((n < 0) == (d < 0)) ? -$signed({1'b0, q[64:0]}) : $signed({1'b0, q[64:0]});
    endfunction

    function bit in_box(logic signed [65:0] v, logic signed [CW-1:0] p, logic signed [CW-1:0] q);
      logic signed [65:0] lo;
      logic signed [65:0] hi;
      lo = ((p < q) ? p : q) - $signed({35'd0, tolerance});
      hi = ((p < q) ? q : p) + $signed({35'd0, tolerance});
      return v >= lo && v <= hi;
    endfunction

    function logic [CW-1:0] clamp(logic signed [65:0] v, inout bit flag);
      if (v > 66'sd2147483647) begin
        flag = 1;
        return 32'h7fffffff;
      end
      if (v < -66'sd2147483648) begin
        flag = 1;
        return 32'h80000000;
      end
      return v[CW-1:0];
    endfunction

    function logic [RW-1:0] crossing(seg_pair_t it);
      logic signed [191:0] ax, ay, bx, by, cx, cy, dx, dy;
      logic signed [191:0] a1, b1, a2, b2, c1, c2, den, nx, ny;
      logic signed [65:0] x, y;
      logic [RW-1:0] r;
      bit hit;
      bit flag;
      ax = it.pt[0]; ay = it.pt[1]; bx = it.pt[2]; by = it.pt[3];
      cx = it.pt[4]; cy = it.pt[5]; dx = it.pt[6]; dy = it.pt[7];
      a1 = ay - by; b1 = bx - ax; a2 = cy - dy; b2 = dx - cx;
      c1 = ax * by - bx * ay;
      c2 = cx * dy - dx * cy;
      den = a1 * b2 - a2 * b1;
      r = '0;
      if (den == 0) begin
        r[1] = 1'b1;
        return r;
      end
      nx = c1 * b2 - c2 * b1;
      ny = a1 * c2 - a2 * c1;
      x = rounded_quot(nx, den);
      y = rounded_quot(ny, den);
      hit = 1;
      if (it.func != FUNC_LINE_LINE)
        hit = in_box(x, it.pt[4], it.pt[6]) && in_box(y, it.pt[5], it.pt[7]);
      if (it.func >= FUNC_SEG_SEG)
        hit = hit && in_box(x, it.pt[0], it.pt[2]) && in_box(y, it.pt[1], it.pt[3]);
      flag = 0;
      r[0] = hit;
      r[33:2] = clamp(x, flag);
      r[65:34] = clamp(y, flag);
      r[66] = flag;
      return r;
    endfunction

    function void note_input(seg_pair_t it);
      pending.push_back(crossing(it));
    endfunction

    function void check_result(logic [RW-1:0] got);
      logic [RW-1:0] want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      hits += want[0];
      parallels += want[1];
      saturations += want[66];
      if (got[0] !== want[0]) begin
        $error("hit: expected %0d, got %0d", want[0], got[0]); errors++;
      end
      if (got[1] !== want[1]) begin
        $error("parallel: expected %0d, got %0d", want[1], got[1]); errors++;
      end
      if (got[33:2] !== want[33:2]) begin
        $error("cross_x: expected %h, got %h", want[33:2], got[33:2]); errors++;
      end
      if (got[65:34] !== want[65:34]) begin
        $error("cross_y: expected %h, got %h", want[65:34], got[65:34]); errors++;
      end
      if (got[66] !== want[66]) begin
        $error("saturated: expected %0d, got %0d", want[66], got[66]); errors++;
      end
      if (got[RW-1:67] !== '0) begin
        $error("fill: expected 0, got %h", got[RW-1:67]); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [TOL_WIDTH-1:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [8*CW-1:0] s_tdata;
  logic [FUNC_WIDTH-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [RW-1:0] m_tdata;

  crossing_scoreboard sb;
  seg_pair_t cur;
  longint cycles;
  bit hold_sink;
  int sent;

  segment_intersection_2d DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(cur);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_sink) m_tready <= 0;
    else if (sent > 300 && sent < 450) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 99) < 70);
  end

  task automatic write_tolerance(logic [TOL_WIDTH-1:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.tolerance = v;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_pair(seg_pair_t it);
    int gap;
    logic [8*CW-1:0] coords;
    gap = (sent > 600 && sent < 700) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur = it;
    for (int i = 0; i < 8; i++) coords[i*CW +: CW] = it.pt[i];
    s_tvalid <= 1;
    s_tuser <= it.func;
    s_tdata <= coords;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  function automatic seg_pair_t make_pair(logic [FUNC_WIDTH-1:0] f,
      int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
    seg_pair_t p;
    p.func = f;
    p.pt[0] = x0; p.pt[1] = y0; p.pt[2] = x1; p.pt[3] = y1;
    p.pt[4] = x2; p.pt[5] = y2; p.pt[6] = x3; p.pt[7] = y3;
    return p;
  endfunction

  function automatic int rand_coord(int kind);
    case (kind)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
      default: return $signed($urandom_range(0, 2047)) - 1024;
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int mode, kind, px, py, k;
    p.func = FUNC_WIDTH'($urandom_range(0, 3));
    mode = $urandom_range(0, 99);
    kind = $urandom_range(0, 2);
    if (mode < 40) begin
      // build two segments through a common point
      px = rand_coord(1);
      py = rand_coord(1);
      for (int s = 0; s < 2; s++) begin
        int ddx, ddy, t0, t1;
        ddx = rand_coord(2);
        ddy = rand_coord(2);
        t0 = $urandom_range(0, 300);
        t1 = $urandom_range(0, 300);
        if ($urandom_range(0, 3) == 0) t0 = -t0 - 2;
        p.pt[s*4+0] = px - t0 * ddx;
        p.pt[s*4+1] = py - t0 * ddy;
        p.pt[s*4+2] = px + t1 * ddx;
        p.pt[s*4+3] = py + t1 * ddy;
      end
    end else if (mode < 50) begin
      for (int i = 0; i < 4; i++) p.pt[i] = rand_coord(kind);
      k = rand_coord(2);
      p.pt[4] = p.pt[0] + k; p.pt[5] = p.pt[1] - k;
      p.pt[6] = p.pt[2] + k; p.pt[7] = p.pt[3] - k;
    end else if (mode < 55) begin
      for (int i = 0; i < 8; i++) p.pt[i] = rand_coord(kind);
      p.pt[6] = p.pt[4]; p.pt[7] = p.pt[5];
    end else begin
      for (int i = 0; i < 8; i++) p.pt[i] = rand_coord(kind);
    end
    return p;
  endfunction

  initial begin
    int maxp, minp;
    seg_pair_t d[$];
    logic [TOL_WIDTH-1:0] tols[5];
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    hold_sink = 0;
    sent = 0;
    cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    maxp = 32'h7fffffff;
    minp = 32'h80000000;
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, 65536, 65536, 0, 65536, 65536, 0));
    d.push_back(make_pair(FUNC_LINE_SEG, 0, 0, 65536, 65536, 0, 65536, 65536, 0));
    d.push_back(make_pair(FUNC_SEG_SEG, 0, 0, 65536, 65536, 0, 65536, 65536, 0));
    d.push_back(make_pair(FUNC_SPARE, 0, 0, 65536, 65536, 0, 65536, 65536, 0));
    d.push_back(make_pair(FUNC_SEG_SEG, 0, 0, 10, 10, 20, 0, 30, -10));
    d.push_back(make_pair(FUNC_LINE_SEG, 0, 0, 10, 10, 20, 0, 30, -10));
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, 10, 10, 20, 0, 30, -10));
    d.push_back(make_pair(FUNC_SEG_SEG, 0, 0, 10, 10, 0, 1, 10, 11));
    d.push_back(make_pair(FUNC_SEG_SEG, 5, 5, 5, 5, 0, 1, 10, 11));
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, 1, 0, 0, 1, 2, 0));
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, 2, 0, 1, 0, 0, 3));
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, 3, 1, 0, 1, 3, 0));
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, maxp, 1, 0, 0, maxp, 2));
    d.push_back(make_pair(FUNC_LINE_LINE, 0, 0, minp, 1, 0, 1, minp, 3));
    d.push_back(make_pair(FUNC_LINE_LINE, minp, minp, maxp, maxp, minp, maxp, maxp, minp));
    d.push_back(make_pair(FUNC_SEG_SEG, minp, minp, maxp, maxp, minp, maxp, maxp, minp));
    d.push_back(make_pair(FUNC_LINE_LINE, maxp, 0, maxp, 1, minp, 0, maxp - 1, 1));
    d.push_back(make_pair(FUNC_SEG_SEG, -1, -1, -1, -1, -1, -1, -1, -1));
    d.push_back(make_pair(FUNC_LINE_SEG, 0, 0, 100, 0, 150, -10, 150, 10));
    d.push_back(make_pair(FUNC_LINE_SEG, 0, 0, 100, 0, 166, -10, 166, 10));
    d.push_back(make_pair(FUNC_SEG_SEG, 0, 0, 100, 0, 166, -10, 166, 10));
    d.push_back(make_pair(FUNC_SEG_SEG, 0, 0, 100, 0, 167, -10, 167, 10));
    foreach (d[i]) send_pair(d[i]);
    idle_input();
    drain();

    tols[0] = '0;
    tols[1] = 31'h7fffffff;
    tols[2] = 31'd1;
    tols[3] = TOL_WIDTH'($urandom_range(0, 31'h7fffffff));
    tols[4] = TOL_WIDTH'($urandom_range(0, 70000));
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tols[ph]);
      if (ph == 0) foreach (d[i]) send_pair(d[i]);
      for (int n = 0; n < 205; n++) begin
        if (ph == 1 && n == 20) begin
          fork
            begin
              hold_sink = 1;
              repeat (LATENCY * 10) @(posedge clk);
              hold_sink = 0;
            end
          join_none
        end
        send_pair(random_pair());
      end
      idle_input();
      drain();
    end

    $display("sent %0d segment pairs over 6 tolerance settings; %0d results checked",
             sent, sb.checked);
    $display("hits %0d, parallel %0d, saturated %0d, mismatches %0d",
             sb.hits, sb.parallels, sb.saturations, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
design/sgi_pkg.sv
design/sgi_coef.sv
design/sgi_div.sv
design/sgi_fin.sv
design/segment_intersection_2d.sv
tb/segment_intersection_2d_tb.sv
